@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL of the occurrence counter.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define POC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define POC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/poc_pkg.sv @@
// Types and sizing constants of the pattern occurrence counter.
// No dependencies; imported by pattern_occurrence_counter and its testbench.
package poc_pkg;

  localparam int TEXT_MAX = 1024;
  localparam int TEXT_AW  = $clog2(TEXT_MAX);
  localparam int TEXT_LW  = $clog2(TEXT_MAX + 1);

  localparam int PAT_MAX = 32;
  localparam int PAT_AW  = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int PAT_LW  = $clog2(PAT_MAX + 1);

  localparam int SYM_W = 8;
  localparam int OCC_W = 11;
  localparam logic [OCC_W-1:0] OCC_MAX = '1;

  localparam logic OP_TEXT    = 1'b0;
  localparam logic OP_PATTERN = 1'b1;

  typedef struct packed {
    logic             op;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [OCC_W-1:0] occurrences;
    logic             overflow;
  } out_item_t;

endpackage

@@ rtl/pattern_occurrence_counter.sv @@
// Channel  | Dir | Payload     | Notes
// in_      | in  | in_item_t   | text or pattern byte, last ends text/pattern
// out_     | out | out_item_t  | one transfer per completed pattern
//
// Text and non-final pattern bytes are accepted back to back.
// A pattern's last byte starts a sweep of the text memory, one stored byte per cycle
// (single read port), then passes ST_TAIL; ST_RESULT loads the result and is entered
// directly on empty text.
// in_ready is low from the sweep's start until its result is loaded; a pending result blocks only the next sweep's end.
// rst_n is synchronous, active low; the text and pattern stores are not cleared.
// Depends on poc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pattern_occurrence_counter import poc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_TAIL, ST_RESULT} state_t;

  state_t              state_r;
  logic                text_open_r;
  logic [TEXT_LW-1:0]  text_len_r;
  logic [PAT_LW-1:0]   pat_len_r;
  logic                ovf_r;
  logic                out_valid_r;
  out_item_t           out_data_r;
  logic                rd_vld_r;
  logic [TEXT_AW-1:0]  rd_addr_r;
  logic [SYM_W-1:0]    rd_data_r;
  logic [PAT_AW-1:0]   hit_idx_r;
  logic [OCC_W-1:0]    count_r;
  logic [PAT_MAX-1:0]  match_r;
  logic [PAT_MAX-1:0]  match_nxt;
  logic [PAT_MAX-1:0]  sym_eq;

  logic [SYM_W-1:0]    text_mem [TEXT_MAX];
  logic [SYM_W-1:0]    pat_r [PAT_MAX];

  logic                in_fire;
  logic                is_text;
  logic [TEXT_LW-1:0]  txt_base;
  logic                txt_room;
  logic                pat_room;
  logic                mem_we;
  logic                pat_we;
  logic                sweep_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_text   = (in_data.op == OP_TEXT);
  // a text byte arriving after the text was closed starts a new one
  assign txt_base  = text_open_r ? text_len_r : '0;
  assign txt_room  = (txt_base < TEXT_LW'(TEXT_MAX));
  assign pat_room  = (pat_len_r < PAT_LW'(PAT_MAX));
  assign mem_we    = in_fire && is_text && txt_room;
  assign pat_we    = in_fire && !is_text && pat_room;
  assign sweep_last = ((TEXT_LW'(rd_addr_r) + TEXT_LW'(1)) == text_len_r);

  // Shift-and matcher: bit k set when the last k+1 text bytes equal pattern[0..k].
  always_comb begin
    for (int k = 0; k < PAT_MAX; k++) begin
      sym_eq[k] = (pat_r[k] == rd_data_r);
    end
    match_nxt = ((match_r << 1) | PAT_MAX'(1)) & sym_eq;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[txt_base[TEXT_AW-1:0]] <= in_data.symbol;
    end
    rd_data_r <= text_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r[pat_len_r[PAT_AW-1:0]] <= in_data.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      text_open_r <= 1'b0;
      text_len_r  <= '0;
      pat_len_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_SWEEP);
      // in ST_RESULT the load below decides out_valid_r
      if (out_valid_r && out_ready && (state_r != ST_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      if (rd_vld_r) begin
        match_r <= match_nxt;
        if (match_nxt[hit_idx_r] && (count_r != OCC_MAX)) begin
          count_r <= count_r + OCC_W'(1);
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_text) begin
              text_len_r  <= txt_room ? (txt_base + TEXT_LW'(1)) : txt_base;
              ovf_r       <= (text_open_r && ovf_r) || !txt_room;
              text_open_r <= !in_data.last;
              pat_len_r   <= '0;
            end else begin
              text_open_r <= 1'b0;
              if (!pat_room) begin
                ovf_r <= 1'b1;
              end
              if (in_data.last) begin
                pat_len_r <= '0;
                hit_idx_r <= pat_room ? pat_len_r[PAT_AW-1:0] : PAT_AW'(PAT_MAX - 1);
                count_r   <= '0;
                match_r   <= '0;
                rd_addr_r <= '0;
                state_r   <= (text_len_r == '0) ? ST_RESULT : ST_SWEEP;
              end else if (pat_room) begin
                pat_len_r <= pat_len_r + PAT_LW'(1);
              end
            end
          end
        end
        ST_SWEEP: begin
          rd_addr_r <= rd_addr_r + TEXT_AW'(1);
          if (sweep_last) begin
            state_r <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          // last text byte is being matched this cycle
          state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.occurrences <= count_r;
            out_data_r.overflow    <= ovf_r;
            state_r                <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `POC_ASSERT_SAME(a_len_bound, 1'b1, text_len_r <= TEXT_LW'(TEXT_MAX))
  `POC_ASSERT_SAME(a_count_bound, state_r == ST_RESULT, count_r <= text_len_r)
  `POC_ASSERT_NEXT(a_read_follows_sweep, state_r == ST_SWEEP, rd_vld_r)
  `POC_ASSERT_NEXT(a_launch, in_fire && !is_text && in_data.last,
                   (state_r == ST_SWEEP || state_r == ST_RESULT) && pat_len_r == '0)
  `POC_ASSERT_NEXT(a_result_load, state_r == ST_RESULT && (!out_valid_r || out_ready),
                   out_valid_r && state_r == ST_IDLE)

endmodule

@@ test/pattern_occurrence_counter_test.sv @@
// Self-checking testbench for pattern_occurrence_counter: directed and random
// text/pattern streams, occurrence counts predicted in the bench itself.
// Depends on poc_pkg and the pattern_occurrence_counter RTL.
module pattern_occurrence_counter_test;
  import poc_pkg::*;

  typedef logic [SYM_W-1:0] sym_q_t[$];

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pattern_occurrence_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

  // Bench copy of the text/pattern state
  logic [SYM_W-1:0] shadow_text [TEXT_MAX];
  int unsigned      shadow_text_len = 0;
  logic [SYM_W-1:0] shadow_pat [PAT_MAX];
  int unsigned      shadow_pat_len = 0;
  bit               shadow_text_open = 1'b0;
  bit               shadow_overflow = 1'b0;

  out_item_t   expected_counts[$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  bit          quiet_mode = 1'b0;
  int unsigned send_gap_odds = 6;
  int unsigned sink_gap_odds = 6;
  int unsigned sink_stall_left = 0;
  int unsigned long_hold_cycles = 0;

  function automatic logic [OCC_W-1:0] count_text_hits();
    int unsigned hits;
    bit          same;
    hits = 0;
    if (shadow_pat_len > shadow_text_len) return '0;
    for (int unsigned pos = 0; pos + shadow_pat_len <= shadow_text_len; pos++) begin
      same = 1'b1;
      for (int unsigned k = 0; k < shadow_pat_len; k++) begin
        if (shadow_text[pos + k] != shadow_pat[k]) begin
          same = 1'b0;
          break;
        end
      end
      if (same && hits < OCC_MAX) hits++;
    end
    return hits[OCC_W-1:0];
  endfunction

  function automatic void absorb_symbol(input in_item_t item);
    out_item_t res;
    if (item.op == OP_TEXT) begin
      // a text byte after a closed text starts a fresh one
      if (!shadow_text_open) begin
        shadow_text_len = 0;
        shadow_overflow = 1'b0;
        shadow_text_open = 1'b1;
      end
      shadow_pat_len = 0;
      if (shadow_text_len < TEXT_MAX) begin
        shadow_text[shadow_text_len] = item.symbol;
        shadow_text_len++;
      end else begin
        shadow_overflow = 1'b1;
      end
      if (item.last) shadow_text_open = 1'b0;
    end else begin
      shadow_text_open = 1'b0;
      if (shadow_pat_len < PAT_MAX) begin
        shadow_pat[shadow_pat_len] = item.symbol;
        shadow_pat_len++;
      end else begin
        shadow_overflow = 1'b1;
      end
      if (item.last) begin
        res.occurrences = count_text_hits();
        res.overflow = shadow_overflow;
        expected_counts.push_back(res);
        shadow_pat_len = 0;
      end
    end
  endfunction

  function automatic void flag_error(input string what, input out_item_t want,
                                     input out_item_t got);
    error_count++;
    if (error_count <= 10)
      $display("%0t %s: expected occurrences=%0d overflow=%0b, got occurrences=%0d overflow=%0b",
               $realtime, what, want.occurrences, want.overflow, got.occurrences,
               got.overflow);
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        flag_error("unexpected result", '0, out_data);
      end else begin
        if (out_data.occurrences !== expected_counts[0].occurrences ||
            out_data.overflow !== expected_counts[0].overflow)
          flag_error("count mismatch", expected_counts[0], out_data);
        void'(expected_counts.pop_front());
      end
    end
  end

  // Result-side ready: random stall bursts, plus a long hold on request
  always @(posedge clk) begin
    if (sink_stall_left > 0) begin
      out_ready <= 1'b0;
      sink_stall_left--;
    end else if (long_hold_cycles > 0) begin
      out_ready <= 1'b0;
      sink_stall_left = long_hold_cycles - 1;
      long_hold_cycles = 0;
    end else if (!quiet_mode && sink_gap_odds != 0 &&
                 $urandom_range(1, sink_gap_odds) == 1) begin
      out_ready <= 1'b0;
      sink_stall_left = $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One input transfer; valid stays high into the next call unless a gap is taken
  task automatic send_item(input logic op, input logic [SYM_W-1:0] sym, input logic last);
    in_item_t item;
    item.op = op;
    item.symbol = sym;
    item.last = last;
    if (!quiet_mode && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    absorb_symbol(item);
    items_sent++;
  endtask

  task automatic send_text(input sym_q_t txt, input bit close);
    foreach (txt[i]) send_item(OP_TEXT, txt[i], close && (i == txt.size() - 1));
  endtask

  task automatic send_pattern(input sym_q_t pat);
    foreach (pat[i]) send_item(OP_PATTERN, pat[i], i == pat.size() - 1);
  endtask

  task automatic test_empty_text();
    send_pattern('{8'h41});
    send_pattern('{8'h00, 8'hFF});
  endtask

  task automatic test_symbol_extremes();
    send_text('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF}, 1'b1);
    send_pattern('{8'hFF});
    send_pattern('{8'h00, 8'hFF});
    send_pattern('{8'hFF, 8'hFF});
  endtask

  task automatic test_overlap_and_long_pattern();
    send_text('{8'h61, 8'h61, 8'h61, 8'h61}, 1'b1);
    send_pattern('{8'h61, 8'h61});
    send_pattern('{8'h61, 8'h61, 8'h61, 8'h61, 8'h61});
  endtask

  task automatic test_query_closes_text();
    // text left open; the pattern byte closes it
    send_text('{8'h7E, 8'h81, 8'h7E}, 1'b0);
    send_pattern('{8'h7E});
    // next text byte starts over
    send_text('{8'h81}, 1'b1);
    send_pattern('{8'h81});
  endtask

  task automatic test_text_during_pattern();
    send_item(OP_PATTERN, 8'h81, 1'b0);
    send_item(OP_PATTERN, 8'h42, 1'b0);
    send_text('{8'h42, 8'h42}, 1'b1);
    send_pattern('{8'h42});
  endtask

  task automatic test_pattern_full();
    sym_q_t txt;
    sym_q_t pat;
    repeat (40) txt.push_back(8'h3C);
    repeat (PAT_MAX + 2) pat.push_back(8'h3C);
    send_text(txt, 1'b1);
    send_pattern(pat);
    send_pattern('{8'h3C});
    // overflow stays set until a new text
    send_text('{8'h3C, 8'hC3}, 1'b1);
    send_pattern('{8'hC3});
  endtask

  task automatic test_text_full();
    sym_q_t txt;
    for (int i = 0; i < TEXT_MAX + 6; i++) txt.push_back(i < TEXT_MAX ? 8'hA5 : 8'h11);
    send_text(txt, 1'b1);
    send_pattern('{8'hA5});
    send_pattern('{8'h11});
    send_pattern('{8'hA5, 8'hA5});
  endtask

  task automatic test_output_backpressure();
    send_text('{8'h10, 8'h20, 8'h10, 8'h20, 8'h10, 8'h20}, 1'b1);
    long_hold_cycles = 300;
    repeat (5) send_pattern('{8'h10, 8'h20});
    send_pattern('{8'h20});
  endtask

  task automatic run_session();
    logic [SYM_W-1:0] alphabet [3];
    sym_q_t           txt;
    sym_q_t           pat;
    int unsigned      alpha_n;
    int unsigned      txt_len;
    int unsigned      pat_len;
    int unsigned      start;
    for (int i = 0; i < 3; i++) alphabet[i] = SYM_W'($urandom);
    alpha_n = $urandom_range(1, 3);
    send_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
    sink_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
    if ($urandom_range(0, 29) == 0) txt_len = $urandom_range(100, 400);
    else txt_len = $urandom_range(0, 40);
    repeat (txt_len) txt.push_back(alphabet[$urandom_range(0, alpha_n - 1)]);
    if (txt_len > 0) send_text(txt, $urandom_range(0, 5) != 0);
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 19) == 0) pat_len = $urandom_range(PAT_MAX - 2, PAT_MAX + 4);
      else pat_len = $urandom_range(1, 6);
      pat = {};
      if (txt.size() >= pat_len && $urandom_range(0, 1) == 1) begin
        start = $urandom_range(0, txt.size() - pat_len);
        for (int k = 0; k < pat_len; k++) pat.push_back(txt[start + k]);
      end else begin
        repeat (pat_len) pat.push_back(alphabet[$urandom_range(0, alpha_n - 1)]);
      end
      send_pattern(pat);
    end
    // noise: fully random items, or a pattern cut short by a text byte
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), SYM_W'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 3)) send_item(OP_PATTERN, SYM_W'($urandom), 1'b0);
        send_item(OP_TEXT, SYM_W'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random_sessions(input int unsigned item_goal);
    int unsigned stop_at;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) run_session();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_text();
    test_symbol_extremes();
    test_overlap_and_long_pattern();
    test_query_closes_text();
    test_text_during_pattern();
    test_pattern_full();
    test_output_backpressure();
    test_text_full();
    test_random_sessions(540);
    quiet_mode = 1'b1;
    test_random_sessions(40);
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (TEXT_MAX + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/poc_pkg.sv
rtl/pattern_occurrence_counter.sv
test/pattern_occurrence_counter_test.sv
